### rtl/assert_macros.svh
// Assertion macros for the RTL of the popcount product block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error(msg);

// Check that an expression is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk_s, rst_s, expr, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error(msg);

`else

`define ASSERT_PROP(label, clk_s, rst_s, prop, msg)

`define ASSERT_NEVER(label, clk_s, rst_s, expr, msg)

`endif

`endif

### rtl/ppm_pkg.sv
// Types and constants shared by the popcount product block.
`default_nettype none

package ppm_pkg;

  // Fixed field widths
  localparam int LIMIT_WIDTH = 50;
  localparam int MOD_WIDTH   = 32;
  localparam int COUNT_WIDTH = LIMIT_WIDTH + 1;
  localparam int ONES_WIDTH  = $clog2(LIMIT_WIDTH + 1);

  localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = 32'd10000007;

  // One Pascal row of binomials and the vector of class counts
  typedef logic [LIMIT_WIDTH-1:0] row_t [LIMIT_WIDTH];
  typedef logic [COUNT_WIDTH-1:0] count_vec_t [COUNT_WIDTH];

  // Main sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_POW,
    S_MUL,
    S_NEXT,
    S_FINISH
  } seq_state_t;

  // Where a finished modular product is written back
  typedef enum logic [1:0] {
    DEST_ACC,
    DEST_PACC,
    DEST_BASE
  } mul_dest_t;

  // Modular multiply unit
  typedef enum logic [1:0] {
    MM_IDLE,
    MM_RED,
    MM_DONE
  } mm_state_t;

endpackage

`default_nettype wire

### rtl/ppm_mulmod.sv
// Shared modular multiply unit: one 32x32 product, then bit-serial reduction.
`default_nettype none

module ppm_mulmod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ppm_pkg::MOD_WIDTH-1:0] a,
  input  logic [ppm_pkg::MOD_WIDTH-1:0] b,
  input  logic [ppm_pkg::MOD_WIDTH:0]   m,
  output logic                         done,
  output logic [ppm_pkg::MOD_WIDTH-1:0] r
);
  import ppm_pkg::*;

  localparam int STEP_WIDTH = $clog2(MOD_WIDTH);
  localparam int PROD_WIDTH = 2 * MOD_WIDTH;

  mm_state_t              state;
  mm_state_t              state_next;
  logic [PROD_WIDTH-1:0]  prod;
  logic [MOD_WIDTH:0]     rem;
  logic [MOD_WIDTH:0]     rem_next;
  logic [MOD_WIDTH-1:0]   low;
  logic [STEP_WIDTH-1:0]  step;
  logic [MOD_WIDTH+1:0]   trial;
  logic [MOD_WIDTH+1:0]   diff;
  logic                   fits;

  // Full product of the two operands
  assign prod = {{MOD_WIDTH{1'b0}}, a} * {{MOD_WIDTH{1'b0}}, b};

  // One restoring step: bring in the next low bit, subtract the modulus if it fits
  always_comb begin
    trial    = {rem, low[MOD_WIDTH-1]};
    diff     = trial - {1'b0, m};
    fits     = (trial >= {1'b0, m});
    rem_next = fits ? diff[MOD_WIDTH:0] : trial[MOD_WIDTH:0];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      MM_IDLE: begin
        if (start) begin
          state_next = MM_RED;
        end
      end
      MM_RED: begin
        if (step == STEP_WIDTH'(MOD_WIDTH - 1)) begin
          state_next = MM_DONE;
        end
      end
      MM_DONE: begin
        state_next = MM_IDLE;
      end
      default: begin
        state_next = MM_IDLE;
      end
    endcase
  end

  // Datapath: the high half is already below the modulus, so it seeds the remainder
  always_ff @(posedge clk) begin
    unique case (state)
      MM_IDLE: begin
        if (start) begin
          rem  <= {1'b0, prod[PROD_WIDTH-1:MOD_WIDTH]};
          low  <= prod[MOD_WIDTH-1:0];
          step <= '0;
        end
      end
      MM_RED: begin
        rem  <= rem_next;
        low  <= low << 1;
        step <= step + STEP_WIDTH'(1);
      end
      default: begin
      end
    endcase
  end

  assign done = (state == MM_DONE);
  assign r    = rem[MOD_WIDTH-1:0];

endmodule

`default_nettype wire

### rtl/popcount_product_mod.sv
// Top level of the popcount product block: class counting scan and modular power sequencer.
`default_nettype none
`include "assert_macros.svh"

// Returns, for an unsigned limit n, the product of popcount(i) over i = 1..n modulo the
// modulus register (zero stands for 2^32, one gives 0, n = 0 gives 1 mod modulus). After a
// beat is taken the block first scans n from its least significant bit, one bit a cycle, up
// to its highest set bit, building the count of every popcount class from a Pascal row held
// in registers. It then walks the classes 1..MAX_BITS through a load and a next step each,
// and raises each class with a nonzero count to that count by square-and-multiply. Every
// modular multiply goes through one shared unit: it is issued, its product is reduced bit
// by bit, and the result is handed back. The input is not ready while an item is at work;
// a finished result waits in an output register, so the next beat may be taken before it
// is collected. The user must write the modulus only while the block is idle; the block
// itself does not enforce this.
module popcount_product_mod #(
  parameter int MAX_BITS = 50
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           upper_limit_valid,
  output logic                           upper_limit_ready,
  input  logic [ppm_pkg::LIMIT_WIDTH-1:0] upper_limit,
  output logic                           product_valid,
  input  logic                           product_ready,
  output logic [ppm_pkg::MOD_WIDTH-1:0]   product,
  input  logic                           modulus_valid,
  output logic                           modulus_ready,
  input  logic [ppm_pkg::MOD_WIDTH-1:0]   modulus
);
  import ppm_pkg::*;

  localparam int K_WIDTH   = $clog2(MAX_BITS + 1);
  localparam int CMP_WIDTH = (K_WIDTH > ONES_WIDTH) ? K_WIDTH : ONES_WIDTH;

  seq_state_t             state;
  seq_state_t             state_next;
  mul_dest_t              dest;
  mul_dest_t              dest_next;

  logic [MOD_WIDTH-1:0]   modulus_reg;
  logic [MOD_WIDTH:0]     m_eff;
  logic [MOD_WIDTH-1:0]   one_val;

  logic [LIMIT_WIDTH-1:0] nsh;
  row_t                   row;
  row_t                   row_adv;
  count_vec_t             cs;
  count_vec_t             cs_add;
  count_vec_t             cs_scan;
  count_vec_t             cs_down;
  logic [ONES_WIDTH-1:0]  ones;
  logic [K_WIDTH-1:0]     k;
  logic                   k_last;
  logic                   own_class;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_load;

  logic [MOD_WIDTH-1:0]   acc;
  logic [MOD_WIDTH-1:0]   pacc;
  logic [MOD_WIDTH-1:0]   base;

  logic                   mul_start;
  logic [MOD_WIDTH-1:0]   mul_a;
  logic [MOD_WIDTH-1:0]   mul_b;
  logic                   mul_done;
  logic [MOD_WIDTH-1:0]   mul_r;

  // Modulus register; zero stands for 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg <= MODULUS_RESET;
    end else if (modulus_valid) begin
      modulus_reg <= modulus;
    end
  end

  assign modulus_ready = 1'b1;
  assign m_eff         = {(modulus_reg == '0), modulus_reg};
  assign one_val       = (modulus_reg == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

  // Advance the Pascal row one step
  always_comb begin
    row_adv[0] = row[0];
    for (int i = 1; i < LIMIT_WIDTH; i++) begin
      row_adv[i] = row[i] + row[i-1];
    end
  end

  // Add the row into the counts at a set bit, then realign when a set bit drops out above
  always_comb begin
    for (int i = 0; i < LIMIT_WIDTH; i++) begin
      cs_add[i] = cs[i] + (nsh[0] ? {1'b0, row[i]} : '0);
    end
    cs_add[LIMIT_WIDTH] = cs[LIMIT_WIDTH];
    cs_scan[0] = nsh[1] ? '0 : cs_add[0];
    for (int i = 1; i < COUNT_WIDTH; i++) begin
      cs_scan[i] = nsh[1] ? cs_add[i-1] : cs_add[i];
    end
  end

  // Step to the next class
  always_comb begin
    for (int i = 0; i < LIMIT_WIDTH; i++) begin
      cs_down[i] = cs[i+1];
    end
    cs_down[LIMIT_WIDTH] = '0;
  end

  // Count of the current class, with n itself added to its own class
  assign own_class = (CMP_WIDTH'(ones) == CMP_WIDTH'(k));
  assign cnt_load  = cs[1] + COUNT_WIDTH'(own_class);
  assign k_last    = (k == K_WIDTH'(MAX_BITS));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiply requests
  always_comb begin
    state_next = state;
    dest_next  = dest;
    mul_start  = 1'b0;
    mul_a      = acc;
    mul_b      = pacc;
    unique case (state)
      S_IDLE: begin
        if (upper_limit_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (nsh[LIMIT_WIDTH-1:1] == '0) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = (cnt_load == '0) ? S_NEXT : S_POW;
      end
      S_POW: begin
        if (cnt == '0) begin
          mul_start  = 1'b1;
          mul_a      = acc;
          mul_b      = pacc;
          dest_next  = DEST_ACC;
          state_next = S_MUL;
        end else if (cnt[0]) begin
          mul_start  = 1'b1;
          mul_a      = pacc;
          mul_b      = base;
          dest_next  = DEST_PACC;
          state_next = S_MUL;
        end else if (cnt[COUNT_WIDTH-1:1] != '0) begin
          mul_start  = 1'b1;
          mul_a      = base;
          mul_b      = base;
          dest_next  = DEST_BASE;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = (dest == DEST_ACC) ? S_NEXT : S_POW;
        end
      end
      S_NEXT: begin
        state_next = k_last ? S_FINISH : S_LOAD;
      end
      S_FINISH: begin
        if (!product_valid || product_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign upper_limit_ready = (state == S_IDLE);

  // Datapath registers
  always_ff @(posedge clk) begin
    dest <= dest_next;
    unique case (state)
      S_IDLE: begin
        if (upper_limit_valid) begin
          nsh <= upper_limit;
          for (int i = 0; i < LIMIT_WIDTH; i++) begin
            row[i] <= '0;
          end
          row[0] <= LIMIT_WIDTH'(1);
          for (int i = 0; i < COUNT_WIDTH; i++) begin
            cs[i] <= '0;
          end
          ones <= '0;
          k    <= K_WIDTH'(1);
          acc  <= one_val;
        end
      end
      S_SCAN: begin
        nsh  <= nsh >> 1;
        row  <= row_adv;
        cs   <= cs_scan;
        ones <= ones + ONES_WIDTH'(nsh[0]);
      end
      S_LOAD: begin
        cnt  <= cnt_load;
        pacc <= one_val;
        base <= MOD_WIDTH'(k);
      end
      S_POW: begin
        // Drop the low exponent bit once used, else halve the exponent
        if (cnt != '0) begin
          if (cnt[0]) begin
            cnt[0] <= 1'b0;
          end else begin
            cnt <= cnt >> 1;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          case (dest)
            DEST_ACC:  acc  <= mul_r;
            DEST_PACC: pacc <= mul_r;
            DEST_BASE: base <= mul_r;
            default: begin
            end
          endcase
        end
      end
      S_NEXT: begin
        if (!k_last) begin
          k  <= k + K_WIDTH'(1);
          cs <= cs_down;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the result until its beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      product_valid <= 1'b0;
    end else if (state == S_FINISH && (!product_valid || product_ready)) begin
      product_valid <= 1'b1;
    end else if (product_ready) begin
      product_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!product_valid || product_ready)) begin
      product <= acc;
    end
  end

  // Shared modular multiplier
  ppm_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (m_eff),
    .done  (mul_done),
    .r     (mul_r)
  );

  // Checks
  `ASSERT_PROP(a_mul_done_in_wait, clk, rst, mul_done |-> (state == S_MUL),
               "multiply result outside wait")
  `ASSERT_PROP(a_busy_after_beat, clk, rst,
               (upper_limit_valid && upper_limit_ready) |=> !upper_limit_ready,
               "ready after accepted beat")
  `ASSERT_PROP(a_result_from_finish, clk, rst,
               $rose(product_valid) |-> ($past(state) == S_FINISH),
               "result loaded outside finish")
  `ASSERT_NEVER(a_class_zero, clk, rst, (state == S_LOAD) && (k == '0),
                "class index zero in load")

endmodule

`default_nettype wire

### test/popcount_product_checker.sv
// Checker for the popcount product block: predicts every product beat and compares it.
`timescale 1ns / 1ps

module popcount_product_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           upper_limit_valid,
  input  logic                           upper_limit_ready,
  input  logic [ppm_pkg::LIMIT_WIDTH-1:0] upper_limit,
  input  logic                           product_valid,
  input  logic                           product_ready,
  input  logic [ppm_pkg::MOD_WIDTH-1:0]   product,
  input  logic                           modulus_valid,
  input  logic                           modulus_ready,
  input  logic [ppm_pkg::MOD_WIDTH-1:0]   modulus,
  output int                             errors,
  output int                             pending
);
  import ppm_pkg::*;

  // Highest popcount class that enters the product (block default)
  localparam int TOP_CLASS = 50;

  // pascal[p][j] holds p choose j
  longint unsigned      pascal [LIMIT_WIDTH][LIMIT_WIDTH];
  logic [MOD_WIDTH-1:0] modulus_now;
  logic [MOD_WIDTH-1:0] expected_products [$];

  // Fill the binomial table once
  initial begin
    for (int i = 0; i < LIMIT_WIDTH; i++) begin
      for (int j = 0; j < LIMIT_WIDTH; j++) begin
        pascal[i][j] = 0;
      end
      pascal[i][0] = 1;
      for (int j = 1; j <= i; j++) begin
        pascal[i][j] = pascal[i-1][j-1] + ((j < i) ? pascal[i-1][j] : 64'd0);
      end
    end
  end

  function automatic longint unsigned mod_mul(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned m);
    return (a * b) % m;
  endfunction

  // Product of popcount(i) for i = 1..n, modulo m; a zero modulus stands for 2^32
  function automatic logic [MOD_WIDTH-1:0] popcount_product(input logic [LIMIT_WIDTH-1:0] n,
                                                            input logic [MOD_WIDTH-1:0] m);
    longint unsigned class_size [LIMIT_WIDTH+1];
    longint unsigned span;
    longint unsigned acc;
    longint unsigned power;
    longint unsigned base;
    longint unsigned exponent;
    int ones;
    span = (m == '0) ? 64'h1_0000_0000 : {32'd0, m};
    for (int k = 0; k <= LIMIT_WIDTH; k++) begin
      class_size[k] = 0;
    end
    // Walk n from the top: clearing a set bit frees every bit below it
    ones = 0;
    for (int p = LIMIT_WIDTH - 1; p >= 0; p--) begin
      if (n[p]) begin
        for (int k = ones; k <= ones + p; k++) begin
          class_size[k] += pascal[p][k-ones];
        end
        ones++;
      end
    end
    class_size[ones] += 1;
    // Raise each class to its size by square-and-multiply
    acc = 1 % span;
    for (int k = 1; k <= TOP_CLASS; k++) begin
      if (class_size[k] != 0) begin
        power = 1 % span;
        base = k % span;
        exponent = class_size[k];
        while (exponent != 0) begin
          if (exponent[0]) begin
            power = mod_mul(power, base, span);
          end
          base = mod_mul(base, base, span);
          exponent = exponent >> 1;
        end
        acc = mod_mul(acc, power, span);
      end
    end
    return acc[MOD_WIDTH-1:0];
  endfunction

  // Track the register, predict on each limit beat, check each product beat
  always @(posedge clk) begin
    logic [MOD_WIDTH-1:0] wanted;
    if (rst) begin
      modulus_now = MODULUS_RESET;
      expected_products.delete();
    end else begin
      if (modulus_valid && modulus_ready) begin
        modulus_now = modulus;
      end
      if (product_valid && product_ready) begin
        if (expected_products.size() == 0) begin
          errors++;
          $display("%0t: product beat %0d arrived, expected none", $time, product);
        end else begin
          wanted = expected_products.pop_front();
          if (product !== wanted) begin
            errors++;
            $display("%0t: product mismatch: expected %0d, got %0d", $time, wanted, product);
          end
        end
      end
      if (upper_limit_valid && upper_limit_ready) begin
        expected_products.push_back(popcount_product(upper_limit, modulus_now));
      end
    end
    pending = expected_products.size();
  end

endmodule

### test/tb_popcount_product_mod.sv
// Testbench top for the popcount product block: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_popcount_product_mod;
  import ppm_pkg::*;

  typedef logic [LIMIT_WIDTH-1:0] limit_t;

  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 17;
  localparam int PRESSURE_PHASE   = 4;
  localparam int PRESSURE_ITEMS   = 4;
  localparam int HOLDOFF_CYCLES   = 2500;
  localparam int SETTLE_CYCLES    = 100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 upper_limit_valid = 1'b0;
  logic                 upper_limit_ready;
  limit_t               upper_limit = '0;
  logic                 product_valid;
  logic                 product_ready = 1'b0;
  logic [MOD_WIDTH-1:0] product;
  logic                 modulus_valid = 1'b0;
  logic                 modulus_ready;
  logic [MOD_WIDTH-1:0] modulus = '0;
  int                   errors;
  int                   pending;

  bit idling = 1'b0;
  bit hold_request = 1'b0;

  popcount_product_mod dut (.*);

  popcount_product_checker checker_i (.*);

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // Keep most limits narrow: run time grows steeply with the width of n
  function automatic limit_t pick_limit();
    int r;
    int w;
    logic [63:0] raw;
    r = $urandom_range(0, 99);
    if (r < 2) w = LIMIT_WIDTH;
    else if (r < 12) w = $urandom_range(11, 20);
    else w = $urandom_range(0, 10);
    raw = {$urandom, $urandom};
    return raw[LIMIT_WIDTH-1:0] & ((limit_t'(1) << w) - limit_t'(1));
  endfunction

  // Offer one limit beat; valid stays high into the next beat when no gap follows
  task automatic offer_limit(input limit_t n, input bit with_gaps);
    int gap;
    upper_limit <= n;
    upper_limit_valid <= 1'b1;
    do @(posedge clk); while (!upper_limit_ready);
    gap = with_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      upper_limit_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding product has come back
  task automatic drain();
    upper_limit_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_WIDTH-1:0] value);
    modulus <= value;
    modulus_valid <= 1'b1;
    do @(posedge clk); while (!modulus_ready);
    modulus_valid <= 1'b0;
  endtask

  // Receiver: random ready pattern, steady when idling is off, long hold-off on request
  initial begin : receiver
    bit level;
    int span;
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        product_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if (!idling) begin
        product_ready <= 1'b1;
        @(posedge clk);
      end else begin
        level = ($urandom_range(0, 3) != 0);
        span = level ? $urandom_range(1, 8) : pick_gap() + 1;
        product_ready <= level;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    limit_t               corner_limits [14];
    logic [MOD_WIDTH-1:0] moduli [PHASES];
    corner_limits = '{
      limit_t'(0), limit_t'(1), limit_t'(2), limit_t'(3), limit_t'(4), limit_t'(5),
      limit_t'(7), limit_t'(8), limit_t'(15), limit_t'(16), limit_t'(255), limit_t'(1023),
      {LIMIT_WIDTH{1'b1}}, limit_t'(1) << (LIMIT_WIDTH - 1)
    };
    moduli = '{32'd2, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd65536, 32'd0, 32'd0, MODULUS_RESET};
    moduli[5] = $urandom_range(32'hFFFF_FFFF, 2);
    moduli[6] = $urandom_range(1000, 2);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner limits under the reset modulus, back to back
    foreach (corner_limits[i]) begin
      offer_limit(corner_limits[i], 1'b0);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      write_modulus(moduli[phase]);
      idling = (phase != 3);
      offer_limit('0, idling);
      repeat (ITEMS_PER_PHASE) offer_limit(pick_limit(), idling);
      // Stall the output long enough for the block to back up into its input
      if (phase == PRESSURE_PHASE) begin
        drain();
        hold_request = 1'b1;
        wait (!hold_request);
        repeat (PRESSURE_ITEMS) offer_limit(limit_t'($urandom_range(0, 31)), 1'b0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
